// File: rtl/dtpf_pkg.sv
// Shared constants, codes and helpers for the depth taper profile fill block.
package dtpf_pkg;

  localparam int MAX_DEPTH_DEF      = 1024;
  localparam int COS_TABLE_SIZE_DEF = 1024;

  // long divider: dividend width, quotient bits per stage, stage count
  localparam int DW         = 42;
  localparam int BPS        = 6;
  localparam int DIV_STAGES = DW / BPS;

  // width of the exact sums ahead of saturation
  localparam int VW = 45;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1073741824;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_LINEAR,
    MODE_COSINE,
    MODE_GRADIENT
  } fill_mode_e;

  typedef enum logic [2:0] {
    CFG_FILL_MODE,
    CFG_TAPER_LEN,
    CFG_DEPTH_COUNT,
    CFG_PROPS_PRESENT,
    CFG_GRAD_FIRST,
    CFG_GRAD_SECOND,
    CFG_GRAD_THIRD
  } cfg_idx_e;

  function automatic logic signed [31:0] sat32(input logic signed [VW-1:0] v);
    logic signed [31:0] r;
    if ((&v[VW-1:31]) || !(|v[VW-1:31])) begin
      r = v[31:0];
    end else if (v[VW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// File: rtl/depth_taper_profile_fill.sv
// Depth taper profile fill: pipelined per-sample taper, cosine and gradient evaluator.
//
// Input channel (in_valid_i / in_stall_o): one depth sample per transfer with the
// interface depth, the sample depth and top/bottom values of three properties.
// Output channel (out_valid_o / out_stall_i): one result per input, in order,
// with the three property values and write_enable_o.
// Config channel (cfg_valid_i / cfg_ready_o): register index and data; always
// ready. Write only while no item is in flight.
// Throughput: one item per cycle while not stalled. Stages: the input stage, the
// multiply stage, the divider entry, seven divider stages of six quotient bits
// each, the cosine table read, the cosine multiply and the output register.
// Receiver stall: the whole pipeline holds while the output register is full
// and stalled; in_stall_o follows that, so nothing is dropped or repeated.
// Reset: all valid bits clear, registers return to fill_mode 0, taper_len 1,
// depth_count 1024, props_present 2, gradients 0. The cosine table is a
// constant ROM and needs no load.
module depth_taper_profile_fill
  import dtpf_pkg::*;
#(
  parameter int MAX_DEPTH      = MAX_DEPTH_DEF,
  parameter int COS_TABLE_SIZE = COS_TABLE_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [9:0]         interface_depth_i,
  input  logic [9:0]         sample_depth_i,
  input  logic signed [31:0] top_first_i,
  input  logic signed [31:0] bottom_first_i,
  input  logic signed [31:0] top_second_i,
  input  logic signed [31:0] bottom_second_i,
  input  logic signed [31:0] top_third_i,
  input  logic signed [31:0] bottom_third_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_first_o,
  output logic signed [31:0] value_second_o,
  output logic signed [31:0] value_third_o,
  output logic               write_enable_o
);

  localparam int PW  = $clog2(2 * COS_TABLE_SIZE + 1);
  localparam int IW  = $clog2(COS_TABLE_SIZE + 1);
  localparam int KNW = 11 + $clog2(COS_TABLE_SIZE + 1);

  typedef logic [16:0] rom_t [COS_TABLE_SIZE+1];

  // Q16 raised-cosine weights, (1 - cos(pi*i/N)) / 2
  function automatic rom_t build_rom();
    rom_t             t;
    longint unsigned  a;
    longint unsigned  x2;
    longint unsigned  term;
    longint           sum;
    longint           w;
    for (int i = 0; i <= COS_TABLE_SIZE; i++) begin
      if (2 * i <= COS_TABLE_SIZE) begin
        a    = (PI_Q30 * longint'(i)) / COS_TABLE_SIZE;
        x2   = (a * a) >> 30;
        term = 64'd1073741824;
        sum  = ONE_Q30;
        for (int n = 1; n <= 8; n++) begin
          term = (term * x2) >> 30;
          // Taylor term divisor (2n-1)*2n
          case (n)
            1: term = term / 64'd2;
            2: term = term / 64'd12;
            3: term = term / 64'd30;
            4: term = term / 64'd56;
            5: term = term / 64'd90;
            6: term = term / 64'd132;
            7: term = term / 64'd182;
            default: term = term / 64'd240;
          endcase
          if ((n & 1) == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        w = (ONE_Q30 - sum + 64'sd16384) >>> 15;
        if (w < 0) w = 0;
        if (w > 65536) w = 65536;
        t[i] = 17'(w);
      end else begin
        t[i] = 17'd65536 - t[COS_TABLE_SIZE-i];
      end
    end
    return t;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  typedef struct packed {
    logic [DW-1:0] num;
    logic [9:0]    rem;
  } dv_t;

  typedef struct packed {
    logic             we;
    logic             taper;
    logic             cosm;
    logic [2:0]       pres;
    logic [10:0]      k;
    logic [9:0]       cnt;
    logic [2:0][31:0] top;
    logic [2:0][31:0] bot;
    logic [2:0][32:0] diff;
  } a_t;

  typedef struct packed {
    logic             we;
    logic             taper;
    logic             cosm;
    logic [2:0]       pres;
    logic [2:0][31:0] top;
    logic [2:0][31:0] bot;
    logic [2:0][32:0] diff;
    logic [2:0][44:0] prod;
    logic [2:0][42:0] tailp;
  } b_t;

  typedef struct packed {
    logic                we;
    logic                taper;
    logic                cosm;
    logic [2:0]          pres;
    logic [2:0]          neg;
    logic [2:0][31:0]    top;
    logic [2:0][32:0]    diff;
    logic [2:0][VW-1:0]  tail;
  } c_t;

  typedef struct packed {
    logic                we;
    logic                taper;
    logic                cosm;
    logic [2:0]          pres;
    logic [2:0][31:0]    top;
    logic [2:0][32:0]    diff;
    logic [2:0][VW-1:0]  tail;
    logic [2:0][VW-1:0]  lin;
  } d_t;

  typedef struct packed {
    logic                we;
    logic                taper;
    logic                cosm;
    logic [2:0]          pres;
    logic [2:0][31:0]    top;
    logic [2:0][VW-1:0]  tail;
    logic [2:0][VW-1:0]  lin;
    logic [2:0][50:0]    cprod;
  } e_t;

  // restoring division, BPS quotient bits
  function automatic dv_t div_steps(input logic [DW-1:0] num, input logic [9:0] rem,
                                    input logic [9:0] dvs);
    logic [DW-1:0] n;
    logic [10:0]   r;
    logic [10:0]   t;
    dv_t           res;
    n = num;
    r = {1'b0, rem};
    for (int b = 0; b < BPS; b++) begin
      t = {r[9:0], n[DW-1]};
      n = {n[DW-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t    = t - {1'b0, dvs};
        n[0] = 1'b1;
      end
      r = t;
    end
    res.num = n;
    res.rem = r[9:0];
    return res;
  endfunction

  // configuration registers
  fill_mode_e         mode_q;
  logic [9:0]         taper_len_q;
  logic [10:0]        depth_count_q;
  logic [1:0]         props_q;
  logic signed [31:0] grad_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_NONE;
      taper_len_q   <= 10'd1;
      depth_count_q <= 11'd1024;
      props_q       <= 2'd2;
      grad_q[0]     <= '0;
      grad_q[1]     <= '0;
      grad_q[2]     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FILL_MODE:     mode_q        <= fill_mode_e'(cfg_data_i[1:0]);
        CFG_TAPER_LEN:     taper_len_q   <= cfg_data_i[9:0];
        CFG_DEPTH_COUNT:   depth_count_q <= cfg_data_i[10:0];
        CFG_PROPS_PRESENT: props_q       <= cfg_data_i[1:0];
        CFG_GRAD_FIRST:    grad_q[0]     <= cfg_data_i;
        CFG_GRAD_SECOND:   grad_q[1]     <= cfg_data_i;
        CFG_GRAD_THIRD:    grad_q[2]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [9:0] g_eff;
  logic [9:0] half_g;
  assign g_eff  = (taper_len_q == '0) ? 10'd1 : taper_len_q;
  assign half_g = g_eff >> 1;

  // pipeline advance
  logic out_vld_q;
  logic en;
  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = !en;

  // stage A: depth decode
  logic        a_vld_q;
  a_t          a_q, a_d;
  logic [10:0] nz, zpg, nzm1, e_end, cnt11;
  logic [9:0]  zp, jj;
  logic signed [31:0] tops [3];
  logic signed [31:0] bots [3];

  assign tops[0] = top_first_i;
  assign tops[1] = top_second_i;
  assign tops[2] = top_third_i;
  assign bots[0] = bottom_first_i;
  assign bots[1] = bottom_second_i;
  assign bots[2] = bottom_third_i;

  always_comb begin
    zp    = interface_depth_i;
    jj    = sample_depth_i;
    nz    = ({21'd0, depth_count_q} < MAX_DEPTH) ? depth_count_q : 11'(MAX_DEPTH);
    zpg   = {1'b0, zp} + {1'b0, g_eff};
    nzm1  = nz - 11'd1;
    e_end = (zpg < nzm1) ? zpg : nzm1;
    cnt11 = {1'b0, jj} - e_end - 11'd1;
    a_d.we    = (mode_q != MODE_NONE) && (zp <= jj) && ({1'b0, jj} < nz);
    a_d.taper = ((mode_q == MODE_LINEAR) || (mode_q == MODE_COSINE))
                && ({1'b0, jj} <= e_end);
    a_d.cosm  = (mode_q == MODE_COSINE);
    a_d.pres  = {props_q != 2'd0, props_q[1], 1'b1};
    a_d.k     = {1'b0, jj} - {1'b0, zp} + {10'd0, zp == 10'd0};
    a_d.cnt   = (mode_q == MODE_GRADIENT) ? (jj - zp) : cnt11[9:0];
    for (int p = 0; p < 3; p++) begin
      a_d.top[p]  = tops[p];
      a_d.bot[p]  = bots[p];
      a_d.diff[p] = 33'(bots[p]) - 33'(tops[p]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
    end
  end

  // stage B: products
  logic           b_vld_q;
  b_t             b_q, b_d;
  logic [KNW-1:0] kn_q, kn_d;

  always_comb begin
    b_d.we    = a_q.we;
    b_d.taper = a_q.taper;
    b_d.cosm  = a_q.cosm;
    b_d.pres  = a_q.pres;
    b_d.top   = a_q.top;
    b_d.bot   = a_q.bot;
    b_d.diff  = a_q.diff;
    for (int p = 0; p < 3; p++) begin
      b_d.prod[p]  = 45'($signed(a_q.diff[p]) * $signed({1'b0, a_q.k}));
      b_d.tailp[p] = 43'($signed({1'b0, a_q.cnt}) * grad_q[p]);
    end
    kn_d = KNW'(a_q.k) * KNW'(COS_TABLE_SIZE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q  <= b_d;
      kn_q <= kn_d;
    end
  end

  // divider pipeline: lanes 0..2 linear taper, lane 3 cosine phase
  logic [DIV_STAGES:0]  dv_vld_q;
  logic [3:0][DW-1:0]   dv_num_q  [DIV_STAGES+1];
  logic [3:0][9:0]      dv_rem_q  [DIV_STAGES+1];
  c_t                   dv_side_q [DIV_STAGES+1];
  c_t                   c_d;
  logic [3:0][DW-1:0]   c_num_d;
  logic [44:0]          mag [3];

  always_comb begin
    c_d.we    = b_q.we;
    c_d.taper = b_q.taper;
    c_d.cosm  = b_q.cosm;
    c_d.pres  = b_q.pres;
    c_d.top   = b_q.top;
    c_d.diff  = b_q.diff;
    for (int p = 0; p < 3; p++) begin
      c_d.neg[p]  = b_q.prod[p][44];
      mag[p]      = b_q.prod[p][44] ? (45'd0 - b_q.prod[p]) : b_q.prod[p];
      c_num_d[p]  = mag[p][DW-1:0] + DW'(half_g);
      c_d.tail[p] = VW'($signed(b_q.bot[p])) + VW'($signed(b_q.tailp[p]));
    end
    c_num_d[3] = DW'(kn_q) + DW'(half_g);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en) begin
      dv_vld_q[0] <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_num_q[0]  <= c_num_d;
      dv_rem_q[0]  <= '0;
      dv_side_q[0] <= c_d;
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    dv_t nxt [4];

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        nxt[l] = div_steps(dv_num_q[s][l], dv_rem_q[s][l], g_eff);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[s+1] <= 1'b0;
      end else if (en) begin
        dv_vld_q[s+1] <= dv_vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < 4; l++) begin
          dv_num_q[s+1][l] <= nxt[l].num;
          dv_rem_q[s+1][l] <= nxt[l].rem;
        end
        dv_side_q[s+1] <= dv_side_q[s];
      end
    end
  end

  // stage D: linear sum, cosine table read
  logic              d_vld_q;
  d_t                d_q, d_d;
  logic [16:0]       rom_q;
  logic [PW-1:0]     ph;
  logic [IW-1:0]     rom_idx;
  logic signed [VW-1:0] qs [3];
  c_t                cs;

  always_comb begin
    cs        = dv_side_q[DIV_STAGES];
    d_d.we    = cs.we;
    d_d.taper = cs.taper;
    d_d.cosm  = cs.cosm;
    d_d.pres  = cs.pres;
    d_d.top   = cs.top;
    d_d.diff  = cs.diff;
    d_d.tail  = cs.tail;
    for (int p = 0; p < 3; p++) begin
      qs[p]      = $signed({{(VW-DW){1'b0}}, dv_num_q[DIV_STAGES][p]});
      d_d.lin[p] = VW'($signed(cs.top[p])) + (cs.neg[p] ? -qs[p] : qs[p]);
    end
    ph      = dv_num_q[DIV_STAGES][3][PW-1:0];
    // phase past the table end folds back
    rom_idx = (ph > PW'(COS_TABLE_SIZE)) ? IW'(PW'(2 * COS_TABLE_SIZE) - ph) : IW'(ph);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= dv_vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q   <= d_d;
      rom_q <= COS_ROM[rom_idx];
    end
  end

  // stage E: cosine weight product
  logic e_vld_q;
  e_t   e_q, e_d;

  always_comb begin
    e_d.we    = d_q.we;
    e_d.taper = d_q.taper;
    e_d.cosm  = d_q.cosm;
    e_d.pres  = d_q.pres;
    e_d.top   = d_q.top;
    e_d.tail  = d_q.tail;
    e_d.lin   = d_q.lin;
    for (int p = 0; p < 3; p++) begin
      e_d.cprod[p] = 51'($signed(d_q.diff[p]) * $signed({1'b0, rom_q}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q <= e_d;
    end
  end

  // output stage: round, select, saturate
  logic signed [31:0]   val_q [3];
  logic signed [31:0]   val_d [3];
  logic                 wen_q;
  logic [50:0]          cm [3];
  logic [50:0]          rc [3];
  logic signed [VW-1:0] rcs [3];
  logic signed [VW-1:0] cv [3];
  logic signed [VW-1:0] tv [3];

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      cm[p]  = e_q.cprod[p][50] ? (51'd0 - e_q.cprod[p]) : e_q.cprod[p];
      rc[p]  = (cm[p] + 51'd32768) >> 16;
      rcs[p] = $signed(VW'(rc[p]));
      cv[p]  = VW'($signed(e_q.top[p])) + (e_q.cprod[p][50] ? -rcs[p] : rcs[p]);
      if (e_q.taper) begin
        tv[p] = e_q.cosm ? cv[p] : $signed(e_q.lin[p]);
      end else begin
        tv[p] = $signed(e_q.tail[p]);
      end
      val_d[p] = (e_q.we && e_q.pres[p]) ? sat32(tv[p]) : 32'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q[0] <= val_d[0];
      val_q[1] <= val_d[1];
      val_q[2] <= val_d[2];
      wen_q    <= e_q.we;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign value_first_o  = val_q[0];
  assign value_second_o = val_q[1];
  assign value_third_o  = val_q[2];
  assign write_enable_o = wen_q;

  // unwritten samples carry zero values
  a_zero_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |->
      value_first_o == 0 && value_second_o == 0 && value_third_o == 0)
    else $error("nonzero value on a sample that is not written");

  // backpressure only comes from a full, stalled output register
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // a new result only appears from the last pipeline stage
  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(e_vld_q))
    else $error("result valid without a valid last stage");

  // a stalled pipeline keeps its last stage
  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(e_vld_q))
    else $error("last stage moved during a stall");

endmodule
